// ===== rtl/icc_pkg.sv =====
// Shared types, constants and codes for the image content classifier.
// No dependencies; icc_colormap, icc_classify and the top level import this package.
package icc_pkg;

    localparam int MAX_SAMPLES = 4096;
    localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
    localparam int MUL_W       = CNT_W + 4;

    localparam int CHAN_W      = 8;
    localparam int KEY_W       = 12;
    localparam int MAP_DEPTH   = 1 << KEY_W;
    localparam int EPOCH_W     = 8;

    localparam int SQ_W        = 2 * CHAN_W;
    localparam int ENERGY_W    = SQ_W + 3;
    localparam int NUM_DIFFS   = 6;

    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [KEY_W-1:0]   key_t;
    typedef logic [EPOCH_W-1:0] epoch_t;
    typedef logic [CHAN_W-1:0]  chan_t;

    localparam cnt_t   MAX_COUNT    = CNT_W'(MAX_SAMPLES);
    localparam epoch_t EPOCH_FIRST  = EPOCH_W'(1);
    localparam epoch_t EPOCH_LAST   = {EPOCH_W{1'b1}};
    localparam logic [ENERGY_W-1:0] ENERGY_LIMIT = ENERGY_W'(900);

    typedef enum logic [1:0] {
        CMD_SAMPLE     = 2'd0,
        CMD_SAMPLE_END = 2'd1,
        CMD_END        = 2'd2,
        CMD_SPARE_END  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CLASS_PHOTO      = 2'd0,
        CLASS_GRAPHIC    = 2'd1,
        CLASS_SCREENSHOT = 2'd2,
        CLASS_DRAWING    = 2'd3
    } class_t;

    typedef struct packed {
        logic advance;
        logic take;
        logic frame_end;
        key_t key;
    } map_req_t;

    typedef struct packed {
        logic is_new;
        logic clearing;
        logic last_epoch;
    } map_stat_t;

    typedef struct packed {
        cnt_t samples;
        cnt_t distinct;
        cnt_t edges;
    } tally_t;

endpackage

// ===== rtl/icc_ram.sv =====
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module icc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/icc_colormap.sv =====
// Seen-color map: an epoch-tagged RAM with write bypass and a clearing sweep.
// Depends on icc_pkg and icc_ram.
module icc_colormap (
    input  logic                clk,
    input  logic                rst_n,
    input  icc_pkg::key_t       rd_key,
    input  icc_pkg::map_req_t   req,
    output icc_pkg::map_stat_t  stat
);
    import icc_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } map_state_t;

    map_state_t state_reg, state_next;
    key_t       clr_addr_reg, clr_addr_next;
    epoch_t     epoch_reg, epoch_next;
    logic       prev_valid_reg, prev_valid_next;
    key_t       prev_key_reg, prev_key_next;

    logic       wr_en;
    key_t       wr_addr;
    epoch_t     wr_data;
    epoch_t     rd_data;
    logic       bypass_hit;

    icc_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAP_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (req.advance),
        .rd_addr (rd_key),
        .rd_data (rd_data)
    );

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = req.key;
        wr_data = epoch_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            ST_RUN:
            begin
                wr_en = req.advance & req.take;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        epoch_next    = epoch_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + KEY_W'(1);
                if (clr_addr_reg == {KEY_W{1'b1}})
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (req.advance && req.frame_end)
                begin
                    if (epoch_reg == EPOCH_LAST)
                    begin
                        epoch_next    = EPOCH_FIRST;
                        clr_addr_next = '0;
                        state_next    = ST_CLEAR;
                    end
                    else
                    begin
                        epoch_next = epoch_reg + EPOCH_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        prev_valid_next = prev_valid_reg;
        prev_key_next   = prev_key_reg;
        if (req.advance)
        begin
            prev_valid_next = req.take & ~req.frame_end;
            prev_key_next   = req.key;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            epoch_reg      <= EPOCH_FIRST;
            prev_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            epoch_reg      <= epoch_next;
            prev_valid_reg <= prev_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prev_key_reg <= prev_key_next;
    end

    // Two frame ends can be in flight at once, so the flag rises one epoch early.
    assign bypass_hit      = prev_valid_reg & (prev_key_reg == req.key);
    assign stat.is_new     = req.take & (rd_data != epoch_reg) & ~bypass_hit;
    assign stat.clearing   = (state_reg == ST_CLEAR);
    assign stat.last_epoch = (epoch_reg >= (EPOCH_LAST - EPOCH_W'(1)));

endmodule

// ===== rtl/icc_classify.sv =====
// Frame-end stage: holds the final counts, applies the ratio tests and
// drives the result word. Depends on icc_pkg.
module icc_classify (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  icc_pkg::tally_t  tally,
    output logic             free,
    output logic             class_valid,
    input  logic             class_stall,
    output logic [1:0]       content_class
);
    import icc_pkg::*;

    logic   snap_valid_reg, snap_valid_next;
    tally_t snap_reg;
    logic   class_valid_reg, class_valid_next;
    class_t class_reg;
    class_t class_calc;
    logic   out_open;
    logic   snap_move;

    logic [MUL_W-1:0] s_w, u_w, e_w;
    logic [MUL_W-1:0] u_x10, e_x10, s_x6, s_x4;

    always_comb
    begin
        s_w   = MUL_W'(snap_reg.samples);
        u_w   = MUL_W'(snap_reg.distinct);
        e_w   = MUL_W'(snap_reg.edges);
        u_x10 = (u_w << 3) + (u_w << 1);
        e_x10 = (e_w << 3) + (e_w << 1);
        s_x6  = (s_w << 2) + (s_w << 1);
        s_x4  = s_w << 2;
    end

    always_comb
    begin
        priority if (snap_reg.samples == '0)
        begin
            class_calc = CLASS_DRAWING;
        end
        else if (u_x10 > s_x6)
        begin
            class_calc = CLASS_PHOTO;
        end
        else if (e_x10 > s_x4)
        begin
            class_calc = CLASS_GRAPHIC;
        end
        else if (u_x10 < s_w)
        begin
            class_calc = CLASS_DRAWING;
        end
        else
        begin
            class_calc = CLASS_SCREENSHOT;
        end
    end

    assign out_open  = ~class_valid_reg | ~class_stall;
    assign snap_move = snap_valid_reg & out_open;
    assign free      = ~snap_valid_reg | snap_move;

    always_comb
    begin
        snap_valid_next = snap_valid_reg;
        if (load)
        begin
            snap_valid_next = 1'b1;
        end
        else if (snap_move)
        begin
            snap_valid_next = 1'b0;
        end

        class_valid_next = class_valid_reg;
        if (snap_move)
        begin
            class_valid_next = 1'b1;
        end
        else if (!class_stall)
        begin
            class_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            snap_valid_reg  <= 1'b0;
            class_valid_reg <= 1'b0;
        end
        else
        begin
            snap_valid_reg  <= snap_valid_next;
            class_valid_reg <= class_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            snap_reg <= tally;
        end
        if (snap_move)
        begin
            class_reg <= class_calc;
        end
    end

    assign class_valid   = class_valid_reg;
    assign content_class = class_reg;

endmodule

// ===== rtl/image_content_classifier.sv =====
// Top level of the image content classifier: input stages, edge test,
// per-frame counters. Depends on icc_pkg, icc_colormap and icc_classify.
//
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+------------------------------------
//  sample   | sample_valid / sample_stall | cmd, center_pixel, right_pixel,
//           |                             | below_pixel
//  class    | class_valid / class_stall   | content_class
//
// One word is accepted per clock while sample_stall is low; a frame-end word
// passes stage A, stage B, the snapshot stage and the class register before
// its class word is shown. After reset the seen-map RAM is swept through all
// 4096 entries with sample_stall high; the same sweep follows every 255th
// frame end, since the map's 8-bit epoch tag then wraps.
// A stalled class word holds one more frame result in the snapshot stage;
// only a further frame end then stalls the input.
module image_content_classifier (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        sample_valid,
    output logic        sample_stall,
    input  logic [1:0]  cmd,
    input  logic [23:0] center_pixel,
    input  logic [23:0] right_pixel,
    input  logic [23:0] below_pixel,
    output logic        class_valid,
    input  logic        class_stall,
    output logic [1:0]  content_class
);
    import icc_pkg::*;

    logic  valid_a_reg, valid_a_next;
    logic  sample_a_reg;
    logic  end_a_reg;
    key_t  key_a_reg;
    chan_t diff_a_reg [NUM_DIFFS];

    logic  valid_b_reg, valid_b_next;
    logic  sample_b_reg;
    logic  end_b_reg;
    key_t  key_b_reg;
    logic  edge_b_reg;

    cnt_t  sample_total_reg, sample_total_next;
    cnt_t  distinct_reg, distinct_next;
    cnt_t  edge_total_reg, edge_total_next;

    logic      accept;
    logic      advance;
    logic      b_blocked;
    logic      epoch_hold;
    logic      class_free;
    logic      snap_load;
    logic      take;
    logic      in_sample;
    logic      in_end;
    logic      edge_a;
    chan_t     diff_in [NUM_DIFFS];
    key_t      key_in;
    tally_t    tally_sum;
    map_req_t  map_req;
    map_stat_t map_stat;
    logic [ENERGY_W-1:0] energy;

    function automatic chan_t abs_diff(input chan_t a, input chan_t b);
        abs_diff = (a >= b) ? (a - b) : (b - a);
    endfunction

    assign in_sample = (cmd == CMD_SAMPLE) || (cmd == CMD_SAMPLE_END);
    assign in_end    = (cmd != CMD_SAMPLE);
    assign key_in    = {center_pixel[23:20], center_pixel[15:12], center_pixel[7:4]};

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            diff_in[2*k]   = abs_diff(center_pixel[8*k +: 8], right_pixel[8*k +: 8]);
            diff_in[2*k+1] = abs_diff(center_pixel[8*k +: 8], below_pixel[8*k +: 8]);
        end
    end

    always_comb
    begin
        energy = '0;
        for (int i = 0; i < NUM_DIFFS; i++)
        begin
            energy = energy + ENERGY_W'(SQ_W'(diff_a_reg[i]) * SQ_W'(diff_a_reg[i]));
        end
        edge_a = (energy > ENERGY_LIMIT);
    end

    assign b_blocked    = valid_b_reg & end_b_reg & ~class_free;
    assign advance      = ~b_blocked;
    assign epoch_hold   = map_stat.last_epoch &
                          ((valid_a_reg & end_a_reg) | (valid_b_reg & end_b_reg));
    assign sample_stall = map_stat.clearing | b_blocked | epoch_hold;
    assign accept       = sample_valid & ~sample_stall;

    assign take = valid_b_reg & sample_b_reg & (sample_total_reg < MAX_COUNT);

    assign map_req.advance   = advance;
    assign map_req.take      = take;
    assign map_req.frame_end = valid_b_reg & end_b_reg;
    assign map_req.key       = key_b_reg;

    icc_colormap u_colormap (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_key (key_a_reg),
        .req    (map_req),
        .stat   (map_stat)
    );

    assign tally_sum.samples  = sample_total_reg + CNT_W'(take);
    assign tally_sum.distinct = distinct_reg + CNT_W'(map_stat.is_new);
    assign tally_sum.edges    = edge_total_reg + CNT_W'(take & edge_b_reg);
    assign snap_load          = advance & valid_b_reg & end_b_reg;

    icc_classify u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (snap_load),
        .tally         (tally_sum),
        .free          (class_free),
        .class_valid   (class_valid),
        .class_stall   (class_stall),
        .content_class (content_class)
    );

    always_comb
    begin
        valid_a_next      = valid_a_reg;
        valid_b_next      = valid_b_reg;
        sample_total_next = sample_total_reg;
        distinct_next     = distinct_reg;
        edge_total_next   = edge_total_reg;
        if (advance)
        begin
            valid_a_next = accept;
            valid_b_next = valid_a_reg;
            if (valid_b_reg)
            begin
                if (end_b_reg)
                begin
                    sample_total_next = '0;
                    distinct_next     = '0;
                    edge_total_next   = '0;
                end
                else
                begin
                    sample_total_next = tally_sum.samples;
                    distinct_next     = tally_sum.distinct;
                    edge_total_next   = tally_sum.edges;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg      <= 1'b0;
            valid_b_reg      <= 1'b0;
            sample_total_reg <= '0;
            distinct_reg     <= '0;
            edge_total_reg   <= '0;
        end
        else
        begin
            valid_a_reg      <= valid_a_next;
            valid_b_reg      <= valid_b_next;
            sample_total_reg <= sample_total_next;
            distinct_reg     <= distinct_next;
            edge_total_reg   <= edge_total_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_a_reg <= in_sample;
            end_a_reg    <= in_end;
            key_a_reg    <= key_in;
            diff_a_reg   <= diff_in;
        end
        if (advance)
        begin
            sample_b_reg <= sample_a_reg;
            end_b_reg    <= end_a_reg;
            key_b_reg    <= key_a_reg;
            edge_b_reg   <= edge_a;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        map_stat.clearing |-> sample_stall)
        else $error("sample word accepted during the map sweep");

    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_total_reg <= MAX_COUNT) && (distinct_reg <= sample_total_reg) &&
        (edge_total_reg <= sample_total_reg))
        else $error("frame counters out of bounds");

    assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |-> class_free)
        else $error("frame result loaded over a pending snapshot");

    assert property (@(posedge clk) disable iff (!rst_n)
        snap_load |=> (sample_total_reg == '0) && (distinct_reg == '0))
        else $error("counters not cleared after frame end");
`endif

endmodule

// ===== test/tb_image_content_classifier.sv =====
// Self-checking testbench for image_content_classifier: directed and random frames,
// predicted in the bench and compared word by word. Depends on icc_pkg and the RTL.
`timescale 1ns / 100ps

module tb_image_content_classifier;

    import icc_pkg::*;

    localparam int EDGE_ENERGY_LIMIT = 900;
    localparam int RANDOM_ITEMS      = 1100;
    localparam int EPOCH_FRAMES      = 520;
    localparam int DRAIN_CYCLES      = 32;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        sample_valid = 1'b0;
    logic        sample_stall;
    logic [1:0]  cmd          = 2'd0;
    logic [23:0] center_pixel = 24'd0;
    logic [23:0] right_pixel  = 24'd0;
    logic [23:0] below_pixel  = 24'd0;
    logic        class_valid;
    logic        class_stall  = 1'b0;
    logic [1:0]  content_class;

    bit     src_idle_en  = 1'b1;
    bit     sink_busy_en = 1'b1;
    int     stall_left   = 0;
    int     fail_count   = 0;

    bit     frame_seen [MAP_DEPTH];
    int     frame_samples = 0;
    int     frame_edges   = 0;
    int     frame_colors  = 0;
    class_t pending_classes [$];

    image_content_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .sample_valid  (sample_valid),
        .sample_stall  (sample_stall),
        .cmd           (cmd),
        .center_pixel  (center_pixel),
        .right_pixel   (right_pixel),
        .below_pixel   (below_pixel),
        .class_valid   (class_valid),
        .class_stall   (class_stall),
        .content_class (content_class)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return $urandom_range(1, 3);
        if (pick < 93)
            return $urandom_range(4, 8);
        return $urandom_range(20, 60);
    endfunction

    function automatic int pixel_energy(logic [23:0] c, logic [23:0] r, logic [23:0] b);
        int sum;
        int dr;
        int db;
        sum = 0;
        for (int k = 0; k < 3; k++)
        begin
            dr = int'(c[8*k +: 8]) - int'(r[8*k +: 8]);
            db = int'(c[8*k +: 8]) - int'(b[8*k +: 8]);
            sum += dr * dr + db * db;
        end
        return sum;
    endfunction

    function automatic class_t frame_class();
        if (frame_samples == 0)
            return CLASS_DRAWING;
        if (10 * frame_colors > 6 * frame_samples)
            return CLASS_PHOTO;
        if (10 * frame_edges > 4 * frame_samples)
            return CLASS_GRAPHIC;
        if (10 * frame_colors < frame_samples)
            return CLASS_DRAWING;
        return CLASS_SCREENSHOT;
    endfunction

    function automatic logic [23:0] color_of(key_t key);
        return {key[11:8], 4'($urandom), key[7:4], 4'($urandom), key[3:0], 4'($urandom)};
    endfunction

    task automatic track_frame(cmd_t op, logic [23:0] c, logic [23:0] r, logic [23:0] b);
        key_t key;
        if ((op == CMD_SAMPLE || op == CMD_SAMPLE_END) && frame_samples < MAX_SAMPLES)
        begin
            key = {c[23:20], c[15:12], c[7:4]};
            if (!frame_seen[key])
            begin
                frame_seen[key] = 1'b1;
                frame_colors++;
            end
            if (pixel_energy(c, r, b) > EDGE_ENERGY_LIMIT)
                frame_edges++;
            frame_samples++;
        end
        if (op != CMD_SAMPLE)
        begin
            pending_classes = {pending_classes, frame_class()};
            frame_seen    = '{default: 1'b0};
            frame_samples = 0;
            frame_edges   = 0;
            frame_colors  = 0;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(cmd_t op, logic [23:0] c, logic [23:0] r, logic [23:0] b);
        int gap;
        gap = (src_idle_en && $urandom_range(0, 2) == 0) ? gap_length() : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_valid <= 1'b1;
        cmd          <= op;
        center_pixel <= c;
        right_pixel  <= r;
        below_pixel  <= b;
        do
            @(posedge clk);
        while (sample_stall);
        track_frame(op, c, r, b);
        @(negedge clk);
    endtask

    task automatic send_flat(cmd_t op, logic [23:0] c);
        send_word(op, c, c, c);
    endtask

    task automatic test_empty_frames();
        send_word(CMD_END, 24'h000000, 24'h000000, 24'h000000);
        send_word(CMD_SPARE_END, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    endtask

    // Energy of exactly 900 is not an edge; 901 is.
    task automatic test_edge_threshold();
        send_word(CMD_SAMPLE, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
        send_word(CMD_SAMPLE, 24'hFFFFFF, 24'h000000, 24'h000000);
        send_word(CMD_SAMPLE, 24'h000000, 24'h1E0000, 24'h000000);
        send_flat(CMD_SAMPLE, 24'h0F0F0F);
        send_flat(CMD_SAMPLE_END, 24'h100000);

        send_word(CMD_SAMPLE, 24'h000000, 24'hFFFFFF, 24'hFFFFFF);
        send_word(CMD_SAMPLE, 24'hFFFFFF, 24'h000000, 24'h000000);
        send_word(CMD_SAMPLE, 24'hFFFFFF, 24'hFFFFFF, 24'hE1FFFE);
        send_flat(CMD_SAMPLE, 24'h0F0F0F);
        send_flat(CMD_SAMPLE_END, 24'h100000);
    endtask

    task automatic test_class_bounds();
        key_t key;
        send_flat(CMD_SAMPLE, 24'h000000);
        send_flat(CMD_SAMPLE, 24'h100000);
        send_flat(CMD_SAMPLE, 24'h001000);
        send_flat(CMD_SAMPLE, 24'h000010);
        send_flat(CMD_SAMPLE_END, 24'h0A0B0C);

        key = 12'h5A5;
        repeat (11) send_flat(CMD_SAMPLE, color_of(key));
        send_word(CMD_SPARE_END, 24'h123456, 24'h654321, 24'hABCDEF);
    endtask

    // Enough back-to-back frames to wrap the map's frame tag more than once.
    task automatic test_map_epoch();
        for (int i = 0; i < EPOCH_FRAMES; i++)
        begin
            if (i % 50 == 0)
            begin
                src_idle_en  = 1'($urandom_range(0, 1));
                sink_busy_en = 1'($urandom_range(0, 1));
            end
            send_word(CMD_SAMPLE_END, color_of(key_t'($urandom_range(0, 7))),
                      24'($urandom), 24'($urandom));
        end
        src_idle_en  = 1'b1;
        sink_busy_en = 1'b1;
    endtask

    task automatic test_random_frames();
        logic [23:0] palette [16];
        logic [23:0] c;
        logic [23:0] r;
        logic [23:0] b;
        int          sent;
        int          frame_len;
        int          colors;
        int          edge_pct;
        int          ending;
        cmd_t        op;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 9) == 0)
                src_idle_en = !src_idle_en;
            if ($urandom_range(0, 9) == 0)
                sink_busy_en = !sink_busy_en;
            case ($urandom_range(0, 4))
                0: colors = 1;
                1: colors = 2;
                2: colors = 4;
                3: colors = 16;
                default: colors = 0;
            endcase
            case ($urandom_range(0, 3))
                0: edge_pct = 0;
                1: edge_pct = 10;
                2: edge_pct = 40;
                default: edge_pct = 80;
            endcase
            frame_len = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 30);
            ending    = $urandom_range(0, 2);
            for (int i = 0; i < 16; i++)
                palette[i] = 24'($urandom);
            for (int i = 0; i < frame_len; i++)
            begin
                c = (colors == 0) ? 24'($urandom) : palette[$urandom_range(0, colors - 1)];
                if ($urandom_range(0, 99) < edge_pct)
                begin
                    r = 24'($urandom);
                    b = 24'($urandom);
                end
                else
                begin
                    r = c ^ (24'($urandom) & 24'h070707);
                    b = c ^ (24'($urandom) & 24'h070707);
                end
                op = CMD_SAMPLE;
                if (i == frame_len - 1 && ending == 0)
                    op = CMD_SAMPLE_END;
                else if ($urandom_range(0, 49) == 0)
                    op = cmd_t'($urandom_range(0, 3));
                send_word(op, c, r, b);
                sent++;
            end
            if (frame_len == 0 || ending != 0)
            begin
                send_word((ending == 2) ? CMD_SPARE_END : CMD_END,
                          24'($urandom), 24'($urandom), 24'($urandom));
                sent++;
            end
        end
    endtask

    always @(negedge clk)
    begin
        if (!rst_n || !sink_busy_en)
        begin
            stall_left = 0;
            class_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            class_stall <= 1'b1;
        end
        else
        begin
            stall_left = ($urandom_range(0, 3) == 0) ? gap_length() : 0;
            class_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    always @(posedge clk)
    begin
        class_t want;
        if (rst_n && class_valid && !class_stall)
        begin
            if (pending_classes.size() == 0)
            begin
                $error("content_class: no class word expected, got %0d", content_class);
                fail_count++;
            end
            else
            begin
                want = pending_classes.pop_front();
                if (content_class !== want)
                begin
                    $error("content_class: expected %0d, got %0d", want, content_class);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        test_empty_frames();
        test_edge_threshold();
        test_class_bounds();
        test_map_epoch();
        test_random_frames();
        sample_valid <= 1'b0;
        while (pending_classes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_image_content_classifier: done, clean");
        else
            $display("tb_image_content_classifier: done, errors");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("tb_image_content_classifier: done, errors");
        $finish;
    end

endmodule

// ===== image_content_classifier.f =====
rtl/icc_pkg.sv
rtl/icc_ram.sv
rtl/icc_colormap.sv
rtl/icc_classify.sv
rtl/image_content_classifier.sv
test/tb_image_content_classifier.sv
